// ===== design/svrt_pkg.sv =====
// Shared types and constants for the sorted version reservation table.
// No dependencies; imported by the key RAM, the top level and the testbench.
`default_nettype none

package svrt_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 64;
   // Stored word: written flag above the key
   localparam int WORD_W      = KEY_W + 1;

   // Command codes
   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_WRITE   = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // Key RAM port controls
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } ram_ctl_type;

endpackage

`default_nettype wire

// ===== design/svrt_key_ram.sv =====
// Key and written-flag store of the version table: one write port, one
// registered read port. Depends on svrt_pkg for depth, word width and the port struct.
`default_nettype none

module svrt_key_ram (
   input  wire logic                      clock,
   input  wire svrt_pkg::ram_ctl_type     ctl,
   output logic [svrt_pkg::WORD_W-1:0]    rd_data
);
   import svrt_pkg::*;

   logic [WORD_W-1:0] mem [TABLE_DEPTH];

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data <= mem[ctl.rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/sorted_version_reservation_table_unit.sv =====
// Top level of the sorted version reservation table: sequencer and count.
// Depends on svrt_pkg and svrt_key_ram.
//
//   channel  handshake                 payload
//   request  start in, busy out        req_cmd, req_batch_num, req_return_num, req_txn_id
//   result   rsp_strobe out (1 cycle)  rsp_status, rsp_version_written,
//                                      rsp_version_key, rsp_version_slot
//
// A word is taken when start is high and busy low. One compare unit walks the
// key and flag RAM one slot per cycle until it reaches the slot found. An insert
// then moves the count-p upper entries (p being the stop slot) one slot each, one
// RAM write per cycle, and then places the new key; busy stays high throughout,
// so no new word is taken until the last one is through.
// Reset is synchronous and leaves one written entry with key 0; no clearing pass.
// The result shows for one cycle and cannot be held off; busy drops with it.
`default_nettype none

module sorted_version_reservation_table_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [15:0]                   req_batch_num,
   input  wire logic [15:0]                   req_return_num,
   input  wire logic [31:0]                   req_txn_id,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_version_written,
   output logic [svrt_pkg::KEY_W-1:0]         rsp_version_key,
   output logic [svrt_pkg::IDX_W-1:0]         rsp_version_slot
);
   import svrt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_INSERT = 2'd3;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   logic [1:0]             state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       sh_ff, sh_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [KEY_W-1:0]       prev_key_ff, prev_key_in;
   logic                   prev_written_ff, prev_written_in;
   logic                   rd_zero_ff, rd_zero_in;

   logic                   strobe_ff, strobe_in;
   logic [1:0]             status_ff, status_in;
   logic                   vwr_ff, vwr_in;
   logic [KEY_W-1:0]       vkey_ff, vkey_in;
   logic [IDX_W-1:0]       vslot_ff, vslot_in;

   ram_ctl_type            ram_ctl;
   logic [WORD_W-1:0]      ram_rd_data;
   logic [KEY_W-1:0]       cur_key;
   logic                   cur_written;
   logic                   advance;
   logic                   found;
   logic [CNT_W-1:0]       pos_next;
   logic [CNT_W-1:0]       pos_prev;
   logic [CNT_W-1:0]       count_prev;
   logic [CNT_W-1:0]       sh_prev;
   logic [CNT_W-1:0]       sh_prev2;
   logic                   accept;

   svrt_key_ram u_key_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (ram_rd_data)
   );

   assign accept      = start && (state_ff == S_IDLE);
   assign busy        = (state_ff != S_IDLE);
   assign cur_key     = rd_zero_ff ? '0 : ram_rd_data[KEY_W-1:0];
   assign cur_written = rd_zero_ff ? 1'b1 : ram_rd_data[KEY_W];
   assign pos_next    = pos_ff + CNT_W'(1);
   assign pos_prev    = pos_ff - CNT_W'(1);
   assign count_prev  = count_ff - CNT_W'(1);
   assign sh_prev     = sh_ff - CNT_W'(1);
   assign sh_prev2    = sh_ff - CNT_W'(2);
   assign advance     = (pos_ff < count_ff) && (cur_key < key_ff);
   assign found       = (pos_ff < count_ff) && (cur_key == key_ff);

   // Sequencer: scan, shift, insert, and drop the result
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      pos_in          = pos_ff;
      sh_in           = sh_ff;
      count_in        = count_ff;
      prev_key_in     = prev_key_ff;
      prev_written_in = prev_written_ff;
      strobe_in       = 1'b0;
      status_in       = status_ff;
      vwr_in          = vwr_ff;
      vkey_in         = vkey_ff;
      vslot_in        = vslot_ff;
      ram_ctl.wr_en   = 1'b0;
      ram_ctl.wr_addr = sh_ff[IDX_W-1:0];
      ram_ctl.wr_data = ram_rd_data;
      ram_ctl.rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               key_in   = {req_batch_num, req_return_num, req_txn_id};
               pos_in   = '0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (advance) begin
               // Step past a smaller key
               pos_in          = pos_next;
               prev_key_in     = cur_key;
               prev_written_in = cur_written;
               ram_ctl.rd_addr = pos_next[IDX_W-1:0];
            end else begin
               ram_ctl.rd_addr = count_prev[IDX_W-1:0];
               strobe_in = 1'b1;
               status_in = ST_OK;
               vwr_in    = 1'b0;
               vkey_in   = '0;
               vslot_in  = '0;
               state_in  = S_IDLE;
               case (cmd_ff)
                  CMD_RESERVE: begin
                     if (found) begin
                        vkey_in  = key_ff;
                        vslot_in = pos_ff[IDX_W-1:0];
                     end else if (count_ff >= DEPTH_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        // Open a gap at the stop slot
                        strobe_in = 1'b0;
                        sh_in     = count_ff;
                        state_in  = (count_ff == pos_ff) ? S_INSERT : S_SHIFT;
                     end
                  end
                  CMD_READ: begin
                     if (pos_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        vwr_in   = prev_written_ff;
                        vkey_in  = prev_key_ff;
                        vslot_in = pos_prev[IDX_W-1:0];
                     end
                  end
                  CMD_WRITE: begin
                     if (found) begin
                        // Mark the entry written; slot zero is written already
                        if (pos_ff != '0) begin
                           ram_ctl.wr_en   = 1'b1;
                           ram_ctl.wr_addr = pos_ff[IDX_W-1:0];
                           ram_ctl.wr_data = {1'b1, key_ff};
                        end
                        vwr_in   = 1'b1;
                        vkey_in  = key_ff;
                        vslot_in = pos_ff[IDX_W-1:0];
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // Move the entry below up one slot, flag and key together
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = sh_ff[IDX_W-1:0];
            ram_ctl.wr_data = ram_rd_data;
            ram_ctl.rd_addr = sh_prev2[IDX_W-1:0];
            sh_in           = sh_prev;
            if (sh_prev == pos_ff) begin
               state_in = S_INSERT;
            end
         end

         S_INSERT: begin
            // Place the new key, not yet written
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = pos_ff[IDX_W-1:0];
            ram_ctl.wr_data = {1'b0, key_ff};
            count_in  = count_ff + CNT_W'(1);
            strobe_in = 1'b1;
            status_in = ST_OK;
            vwr_in    = 1'b0;
            vkey_in   = key_ff;
            vslot_in  = pos_ff[IDX_W-1:0];
            state_in  = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Slot zero always holds key zero, written, and is never stored to
   assign rd_zero_in = (ram_ctl.rd_addr == '0);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= CNT_W'(1);
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      pos_ff          <= pos_in;
      sh_ff           <= sh_in;
      prev_key_ff     <= prev_key_in;
      prev_written_ff <= prev_written_in;
      rd_zero_ff      <= rd_zero_in;
      status_ff       <= status_in;
      vwr_ff          <= vwr_in;
      vkey_ff         <= vkey_in;
      vslot_ff        <= vslot_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_version_written = vwr_ff;
   assign rsp_version_key     = vkey_ff;
   assign rsp_version_slot    = vslot_ff;

   // Entry count stays between one and the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(1)) && (count_ff <= DEPTH_CNT))
      else $error("entry count out of range");

   // The scan never runs past the stored entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (pos_ff <= count_ff))
      else $error("scan position beyond entry count");

   // A result word leaves the block idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while still busy");

   // An accepted word keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted word not being worked");

   // Count grows only through an insert
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == S_INSERT))
      else $error("entry count changed outside insert");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted version reservation table unit.
// Depends on svrt_pkg and the RTL of sorted_version_reservation_table_unit.

module testbench;
   import svrt_pkg::*;

   // Command code the block leaves unused; it answers with an all-zero word
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         NUM_DIRECTED = 24;
   localparam int         PHASE_WORDS  = 500;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;

   typedef struct packed {
      logic [1:0]       status;
      logic             written;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] slot;
   } version_rsp_type;

   // One command word, with an optional hand-typed answer
   typedef struct packed {
      logic [1:0]       cmd;
      logic [15:0]      batch_num;
      logic [15:0]      return_num;
      logic [31:0]      txn_id;
      logic             typed;
      logic [1:0]       status;
      logic             written;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] slot;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]       req_cmd        = '0;
   logic [15:0]      req_batch_num  = '0;
   logic [15:0]      req_return_num = '0;
   logic [31:0]      req_txn_id     = '0;
   logic             rsp_strobe;
   logic [1:0]       rsp_status;
   logic             rsp_version_written;
   logic [KEY_W-1:0] rsp_version_key;
   logic [IDX_W-1:0] rsp_version_slot;

   // Shadow copy of the sorted table
   logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
   logic             shadow_written [TABLE_DEPTH];
   int               shadow_count;

   version_rsp_type due_versions_q [$];
   version_rsp_type due_rsp;

   int sender_idle_pct = 28;
   int cycle_count     = 0;
   int fail_count      = 0;
   int checked_count   = 0;
   int reserve_count   = 0;
   int full_count      = 0;
   int read_count      = 0;
   int write_count     = 0;
   int unused_count    = 0;

   // Directed words: extremes, every command, duplicates, empty lookups
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{CMD_READ,    16'h0000, 16'h0000, 32'h00000000, 1'b1, ST_NOT_FOUND, 1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'hffff, 16'hffff, 32'hffffffff, 1'b1, ST_OK,        1'b1, 64'h0, 6'd0},
      '{CMD_WRITE,   16'h0000, 16'h0000, 32'h00000000, 1'b1, ST_OK,        1'b1, 64'h0, 6'd0},
      '{CMD_WRITE,   16'h0000, 16'h0000, 32'h00000005, 1'b1, ST_NOT_FOUND, 1'b0, 64'h0, 6'd0},
      '{CMD_RESERVE, 16'h0000, 16'h0000, 32'h00000000, 1'b1, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_RESERVE, 16'hffff, 16'hffff, 32'hffffffff, 1'b1, ST_OK,        1'b0, KEY_MAX, 6'd1},
      '{CMD_RESERVE, 16'h0000, 16'h0000, 32'h00000001, 1'b1, ST_OK,        1'b0, 64'h1, 6'd1},
      '{CMD_RESERVE, 16'h8000, 16'h0000, 32'h00000000, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_RESERVE, 16'hffff, 16'hffff, 32'hffffffff, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'hffff, 16'hffff, 32'hffffffff, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'h0000, 16'h0000, 32'h00000001, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'h0000, 16'h0000, 32'h00000002, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_WRITE,   16'h8000, 16'h0000, 32'h00000000, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'hffff, 16'hffff, 32'hffffffff, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_WRITE,   16'hffff, 16'hffff, 32'hffffffff, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_WRITE,   16'h0000, 16'h0000, 32'h00000001, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_RESERVE, 16'h5555, 16'haaaa, 32'h5555aaaa, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_RESERVE, 16'haaaa, 16'h5555, 32'haaaa5555, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'hffff, 16'h0000, 32'h00000000, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_READ,    16'h0000, 16'hffff, 32'hffffffff, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_WRITE,   16'h0000, 16'h0001, 32'h00000000, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_UNUSED,  16'hffff, 16'hffff, 32'hffffffff, 1'b1, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_UNUSED,  16'h0000, 16'h0000, 32'h00000000, 1'b1, ST_OK,        1'b0, 64'h0, 6'd0},
      '{CMD_RESERVE, 16'h0001, 16'h0000, 32'h00000000, 1'b0, ST_OK,        1'b0, 64'h0, 6'd0}
   };

   sorted_version_reservation_table_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_batch_num       (req_batch_num),
      .req_return_num      (req_return_num),
      .req_txn_id          (req_txn_id),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_version_written (rsp_version_written),
      .rsp_version_key     (rsp_version_key),
      .rsp_version_slot    (rsp_version_slot)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one command to the shadow table and return the answer it gives
   function automatic version_rsp_type apply_version_command(input logic [1:0] cmd,
                                                             input logic [KEY_W-1:0] key);
      version_rsp_type r;
      int p;
      int j;
      r = '0;
      p = 0;
      while (p < shadow_count && shadow_key[p] < key) p++;
      case (cmd)
         CMD_RESERVE: begin
            if (p < shadow_count && shadow_key[p] == key) begin
               r = '{ST_OK, 1'b0, key, IDX_W'(p)};
            end else if (shadow_count >= TABLE_DEPTH) begin
               r = '{ST_FULL, 1'b0, '0, '0};
            end else begin
               // shift the upper entries up one slot and place the new key
               for (j = shadow_count; j > p; j--) begin
                  shadow_key[j]     = shadow_key[j-1];
                  shadow_written[j] = shadow_written[j-1];
               end
               shadow_key[p]     = key;
               shadow_written[p] = 1'b0;
               shadow_count++;
               r = '{ST_OK, 1'b0, key, IDX_W'(p)};
            end
         end
         CMD_READ: begin
            if (p == 0) r = '{ST_NOT_FOUND, 1'b0, '0, '0};
            else r = '{ST_OK, shadow_written[p-1], shadow_key[p-1], IDX_W'(p - 1)};
         end
         CMD_WRITE: begin
            if (p < shadow_count && shadow_key[p] == key) begin
               shadow_written[p] = 1'b1;
               r = '{ST_OK, 1'b1, key, IDX_W'(p)};
            end else begin
               r = '{ST_NOT_FOUND, 1'b0, '0, '0};
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // Pick a key: mostly stored keys and their neighbors, some field extremes
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] k;
      int mode;
      mode = $urandom_range(99);
      base = shadow_key[$urandom_range(shadow_count - 1)];
      k    = {$urandom, $urandom};
      if (mode < 40) return base;
      if (mode < 55) return ($urandom_range(1) == 0) ? base + 1 : base - 1;
      if (mode < 65) begin
         case ($urandom_range(2))
            0: k[63:48] = '0;
            1: k[63:48] = '1;
            default: ;
         endcase
         case ($urandom_range(2))
            0: k[47:32] = '0;
            1: k[47:32] = '1;
            default: ;
         endcase
         case ($urandom_range(2))
            0: k[31:0] = '0;
            1: k[31:0] = '1;
            default: ;
         endcase
         return k;
      end
      if (mode < 85) return k;
      return {base[63:32], 32'($urandom_range(15))};
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < 10) $display("%s", msg);
      fail_count++;
   endtask

   // Hold off new words until every answer is back
   task automatic wait_until_answered();
      while (due_versions_q.size() != 0) begin
         start = 1'b0;
         @(negedge clock);
      end
   endtask

   // Offer one word from a falling edge and hold it until taken
   task automatic send_word(input stim_row_type row);
      version_rsp_type predicted;
      version_rsp_type expected;
      while ($urandom_range(99) < sender_idle_pct) begin
         start          = 1'b0;
         req_cmd        = 2'($urandom);
         req_batch_num  = 16'($urandom);
         req_return_num = 16'($urandom);
         req_txn_id     = $urandom;
         @(negedge clock);
      end
      start          = 1'b1;
      req_cmd        = row.cmd;
      req_batch_num  = row.batch_num;
      req_return_num = row.return_num;
      req_txn_id     = row.txn_id;
      do @(posedge clock); while (busy);
      predicted = apply_version_command(row.cmd, {row.batch_num, row.return_num, row.txn_id});
      expected  = row.typed ? version_rsp_type'{row.status, row.written, row.key, row.slot}
                            : predicted;
      due_versions_q.insert(due_versions_q.size(), expected);
      case (row.cmd)
         CMD_RESERVE: begin
            reserve_count++;
            if (predicted.status == ST_FULL) full_count++;
         end
         CMD_READ:  read_count++;
         CMD_WRITE: write_count++;
         default:   unused_count++;
      endcase
      @(negedge clock);
   endtask

   // Check each result word against the oldest answer due
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (due_versions_q.size() == 0) begin
            note_failure($sformatf("unexpected result: status %0d written %0d key %h slot %0d",
                                   rsp_status, rsp_version_written, rsp_version_key,
                                   rsp_version_slot));
         end else begin
            due_rsp = due_versions_q.pop_front();
            checked_count++;
            if (rsp_status !== due_rsp.status || rsp_version_written !== due_rsp.written ||
                rsp_version_key !== due_rsp.key || rsp_version_slot !== due_rsp.slot) begin
               note_failure($sformatf({"mismatch on result %0d: expected status %0d written %0d",
                                       " key %h slot %0d, got status %0d written %0d key %h",
                                       " slot %0d"},
                                      checked_count, due_rsp.status, due_rsp.written,
                                      due_rsp.key, due_rsp.slot, rsp_status,
                                      rsp_version_written, rsp_version_key, rsp_version_slot));
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, due_versions_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      logic [KEY_W-1:0] key;
      int phase;
      int n;
      int roll;

      // table after reset: one written entry holding key 0
      shadow_key[0]     = '0;
      shadow_written[0] = 1'b1;
      for (n = 1; n < TABLE_DEPTH; n++) begin
         shadow_key[n]     = '0;
         shadow_written[n] = 1'b0;
      end
      shadow_count = 1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (n = 0; n < NUM_DIRECTED; n++) send_word(directed_rows[n]);

      // random words in three idling phases: 28 %, 71 %, none
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 71 : 0;
         wait_until_answered();
         for (n = 0; n < PHASE_WORDS; n++) begin
            row  = '0;
            key  = pick_key();
            roll = $urandom_range(99);
            row.cmd = (roll < 25) ? CMD_RESERVE : (roll < 60) ? CMD_READ :
                      (roll < 95) ? CMD_WRITE : CMD_UNUSED;
            {row.batch_num, row.return_num, row.txn_id} = key;
            send_word(row);
            if ($urandom_range(99) == 0) wait_until_answered();
         end
      end

      // drain, then give a stray result time to show up
      start = 1'b0;
      while (due_versions_q.size() != 0) @(negedge clock);
      repeat (2 * TABLE_DEPTH + 8) @(negedge clock);

      $display("covered %0d reserves (%0d refused as full), %0d reads, %0d writes, %0d unused",
               reserve_count, full_count, read_count, write_count, unused_count);
      $display("checked %0d results; table ended with %0d of %0d entries; %0d failures",
               checked_count, shadow_count, TABLE_DEPTH, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
